// ===== src/acws_pkg.sv =====
// ----------------------------------------------------------------------------
// acws_pkg
// Shared types and constants of the alarm clock with snooze.
// ----------------------------------------------------------------------------
package acws_pkg;

	localparam int MAX_BUTTONS = 8;
	localparam int BTN_W       = 3;
	localparam int HIST_W      = 16;
	localparam int TICK_W      = 8;
	localparam int SNZ_W       = 4;
	localparam int HOUR_W      = 5;
	localparam int MIN_W       = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [HIST_W-1:0] HIST_SET   = 16'hE000;
	localparam logic [HIST_W-1:0] HIST_PRESS = 16'hF000;

	localparam logic [MIN_W-1:0]  SEC_PER_MIN   = 6'd60;
	localparam logic [MIN_W-1:0]  MIN_PER_HOUR  = 6'd60;
	localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;

	localparam logic [TICK_W-1:0] TPS_RESET = 8'd128;
	localparam logic [TICK_W-1:0] TPS_MIN   = 8'd2;
	localparam logic [SNZ_W-1:0]  SNZ_RESET = 4'd10;
	localparam logic [SNZ_W-1:0]  SNZ_MIN   = 4'd1;

	localparam logic [CFG_IDX_W-1:0] REG_TPS    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SNOOZE = 1'b1;

	localparam logic [BTN_W-1:0] BTN_MIN_STEP   = 3'd0;
	localparam logic [BTN_W-1:0] BTN_HOUR_STEP  = 3'd1;
	localparam logic [BTN_W-1:0] BTN_RADIO      = 3'd2;
	localparam logic [BTN_W-1:0] BTN_SNOOZE     = 3'd3;
	localparam logic [BTN_W-1:0] BTN_ALARM_EN   = 3'd4;
	localparam logic [BTN_W-1:0] BTN_MODE_ALARM = 3'd5;
	localparam logic [BTN_W-1:0] BTN_MODE_RADIO = 3'd6;
	localparam logic [BTN_W-1:0] BTN_MODE_TIME  = 3'd7;

	typedef enum logic [1:0] {
		MODE_TIME  = 2'd0,
		MODE_RADIO = 2'd1,
		MODE_ALARM = 2'd2
	} mode_t;

	typedef struct packed {
		logic             tick;
		logic             fire;
		logic [BTN_W-1:0] btn;
	} cmd_t;

endpackage

// ===== src/acws_ifs.sv =====
// ----------------------------------------------------------------------------
// acws_ifs
// Valid/ready channels of the alarm clock: input items and status snapshots.
// ----------------------------------------------------------------------------
interface acws_in_if;
	logic                             valid;
	logic                             ready;
	logic                             kind;
	logic [acws_pkg::MAX_BUTTONS-1:0] raw_buttons;

	modport source (output valid, kind, raw_buttons, input ready);
	modport sink   (input valid, kind, raw_buttons, output ready);
endinterface

interface acws_out_if;
	logic                        valid;
	logic                        ready;
	logic [acws_pkg::HOUR_W-1:0] hours;
	logic [acws_pkg::MIN_W-1:0]  minutes;
	logic [acws_pkg::MIN_W-1:0]  seconds;
	logic [acws_pkg::HOUR_W-1:0] alarm_hours;
	logic [acws_pkg::MIN_W-1:0]  alarm_minutes;
	logic [1:0]                  display_mode;
	logic                        alarm_enabled;
	logic                        alarm_sounding;
	logic                        snoozing;
	logic                        colon_on;
	logic                        radio_on;

	modport source (output valid, hours, minutes, seconds, alarm_hours, alarm_minutes,
		display_mode, alarm_enabled, alarm_sounding, snoozing, colon_on, radio_on,
		input ready);
	modport sink (input valid, hours, minutes, seconds, alarm_hours, alarm_minutes,
		display_mode, alarm_enabled, alarm_sounding, snoozing, colon_on, radio_on,
		output ready);
endinterface

// ===== src/acws_front.sv =====
// ----------------------------------------------------------------------------
// acws_front
// Accepts items, debounces the buttons and classifies each item as a tick,
// a button action or nothing.
// ----------------------------------------------------------------------------
module acws_front #(
	parameter int NUM_BUTTONS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	acws_in_if.sink              items,
	input  logic                 push_ready,
	output logic                 push_valid,
	output acws_pkg::cmd_t       push_cmd
);

	logic [acws_pkg::HIST_W-1:0] hist_q  [NUM_BUTTONS];
	logic [acws_pkg::HIST_W-1:0] shifted [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]      upd;
	logic                        lower;
	logic                        fire_any;
	logic [acws_pkg::BTN_W-1:0]  fire_idx;
	logic                        accept;

	assign accept      = items.valid && items.ready;
	assign items.ready = push_ready;
	assign push_valid  = items.valid;

	always_comb begin
		lower    = 1'b0;
		fire_any = 1'b0;
		fire_idx = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			shifted[i] = {hist_q[i][acws_pkg::HIST_W-2:0], items.raw_buttons[i]}
				| acws_pkg::HIST_SET;
			upd[i] = !lower;
			if (!lower && shifted[i] == acws_pkg::HIST_PRESS) begin
				fire_any = 1'b1;
				fire_idx = acws_pkg::BTN_W'(i);
			end
			lower = lower | (shifted[i] == acws_pkg::HIST_PRESS);
		end
	end

	always_comb begin
		push_cmd.tick = !items.kind;
		push_cmd.fire = items.kind && fire_any;
		push_cmd.btn  = fire_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) hist_q[i] <= '0;
		end else if (accept && items.kind) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (upd[i]) hist_q[i] <= shifted[i];
			end
		end
	end

endmodule

// ===== src/acws_queue.sv =====
// ----------------------------------------------------------------------------
// acws_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module acws_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  acws_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output acws_pkg::cmd_t pop_cmd
);

	acws_pkg::cmd_t                entries [acws_pkg::QDEPTH];
	logic [acws_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [acws_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [acws_pkg::QCNT_W-1:0]   count_q;
	logic                          push_fire;
	logic                          pop_fire;

	assign push_ready = count_q != acws_pkg::QCNT_W'(acws_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entries[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) entries[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop_fire) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push_fire && !pop_fire) count_q <= count_q + 1'b1;
			else if (pop_fire && !push_fire) count_q <= count_q - 1'b1;
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push_fire && !pop_fire |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count did not advance on push");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire && !push_fire |=> count_q == $past(count_q) - 2'd1)
		else $error("queue count did not drop on pop");

endmodule

// ===== src/acws_back.sv =====
// ----------------------------------------------------------------------------
// acws_back
// Carries out queued commands on the clock state and presents the snapshot.
// ----------------------------------------------------------------------------
module acws_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pop_valid,
	output logic                                pop_ready,
	input  acws_pkg::cmd_t                      cmd,
	acws_out_if.source                          results,
	input  logic                                wr_en,
	input  logic [acws_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [acws_pkg::CFG_DATA_W-1:0]     wr_data
);

	logic [acws_pkg::TICK_W-1:0] cfg_tps_q;
	logic [acws_pkg::SNZ_W-1:0]  cfg_snz_q;

	logic [acws_pkg::TICK_W-1:0] tick_count_q, tick_n;
	logic [acws_pkg::HOUR_W-1:0] hours_q, hours_n;
	logic [acws_pkg::MIN_W-1:0]  minutes_q, minutes_n;
	logic [acws_pkg::MIN_W-1:0]  seconds_q, seconds_n;
	logic [acws_pkg::HOUR_W-1:0] alarm_hours_q, alarm_hours_n;
	logic [acws_pkg::MIN_W-1:0]  alarm_minutes_q, alarm_minutes_n;
	logic [acws_pkg::SNZ_W-1:0]  snooze_count_q, snooze_count_n;
	acws_pkg::mode_t             mode_q, mode_n;
	logic                        enabled_q, enabled_n;
	logic                        sounding_q, sounding_n;
	logic                        snoozing_q, snoozing_n;
	logic                        colon_q, colon_n;
	logic                        radio_q, radio_n;
	logic                        out_valid_q;

	logic [acws_pkg::TICK_W-1:0] tps;
	logic [acws_pkg::TICK_W-1:0] tc1;
	logic [acws_pkg::SNZ_W-1:0]  snz_lim;
	logic [acws_pkg::MIN_W-1:0]  min_step;
	logic [acws_pkg::HOUR_W-1:0] hour_step;
	logic [acws_pkg::MIN_W-1:0]  amin_step;
	logic [acws_pkg::HOUR_W-1:0] ahour_step;
	logic                        pop_fire;

	assign pop_ready = !out_valid_q || results.ready;
	assign pop_fire  = pop_valid && pop_ready;

	always_comb begin
		tps        = (cfg_tps_q < acws_pkg::TPS_MIN) ? acws_pkg::TPS_MIN : cfg_tps_q;
		tc1        = tick_count_q + 8'd1;
		snz_lim    = (cfg_snz_q == '0) ? acws_pkg::SNZ_MIN : cfg_snz_q;
		min_step   = minutes_q + 6'd1;
		hour_step  = hours_q + 5'd1;
		amin_step  = alarm_minutes_q + 6'd1;
		ahour_step = alarm_hours_q + 5'd1;
		if (min_step >= acws_pkg::MIN_PER_HOUR) min_step = '0;
		if (hour_step >= acws_pkg::HOURS_PER_DAY) hour_step = '0;
		if (amin_step >= acws_pkg::MIN_PER_HOUR) amin_step = '0;
		if (ahour_step >= acws_pkg::HOURS_PER_DAY) ahour_step = '0;

		tick_n          = tick_count_q;
		hours_n         = hours_q;
		minutes_n       = minutes_q;
		seconds_n       = seconds_q;
		alarm_hours_n   = alarm_hours_q;
		alarm_minutes_n = alarm_minutes_q;
		snooze_count_n  = snooze_count_q;
		mode_n          = mode_q;
		enabled_n       = enabled_q;
		sounding_n      = sounding_q;
		snoozing_n      = snoozing_q;
		colon_n         = colon_q;
		radio_n         = radio_q;

		if (cmd.tick) begin
			tick_n = tc1;
			if (tc1 == (tps >> 1) || tc1 >= tps) colon_n = !colon_q;
			if (tc1 >= tps) begin
				tick_n    = '0;
				seconds_n = seconds_q + 6'd1;
				if (seconds_n >= acws_pkg::SEC_PER_MIN) begin
					seconds_n = '0;
					minutes_n = minutes_q + 6'd1;
				end
				if (minutes_n >= acws_pkg::MIN_PER_HOUR) begin
					minutes_n = '0;
					hours_n   = hours_q + 5'd1;
				end
				if (hours_n >= acws_pkg::HOURS_PER_DAY) hours_n = '0;

				if (enabled_q && hours_n == alarm_hours_q && minutes_n == alarm_minutes_q
					&& seconds_n == '0) sounding_n = 1'b1;
				if (!enabled_q) begin
					sounding_n = 1'b0;
					snoozing_n = 1'b0;
				end
				if (snoozing_n) begin
					snooze_count_n = snooze_count_q + 4'd1;
					sounding_n     = 1'b0;
				end
				if (snooze_count_n >= snz_lim) begin
					snoozing_n     = 1'b0;
					sounding_n     = 1'b1;
					snooze_count_n = '0;
				end
			end
		end else if (cmd.fire) begin
			unique case (cmd.btn)
				acws_pkg::BTN_MODE_TIME:  mode_n = acws_pkg::MODE_TIME;
				acws_pkg::BTN_MODE_RADIO: mode_n = acws_pkg::MODE_RADIO;
				acws_pkg::BTN_MODE_ALARM: mode_n = acws_pkg::MODE_ALARM;
				acws_pkg::BTN_ALARM_EN:   enabled_n = !enabled_q;
				acws_pkg::BTN_SNOOZE:     if (sounding_q) snoozing_n = 1'b1;
				acws_pkg::BTN_RADIO:      radio_n = !radio_q;
				acws_pkg::BTN_MIN_STEP: begin
					unique case (mode_q)
						acws_pkg::MODE_TIME:  minutes_n = min_step;
						acws_pkg::MODE_ALARM: alarm_minutes_n = amin_step;
						default: ;
					endcase
				end
				acws_pkg::BTN_HOUR_STEP: begin
					unique case (mode_q)
						acws_pkg::MODE_TIME:  hours_n = hour_step;
						acws_pkg::MODE_ALARM: alarm_hours_n = ahour_step;
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_tps_q <= acws_pkg::TPS_RESET;
			cfg_snz_q <= acws_pkg::SNZ_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				acws_pkg::REG_TPS:    cfg_tps_q <= wr_data;
				acws_pkg::REG_SNOOZE: cfg_snz_q <= wr_data[acws_pkg::SNZ_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= '0;
			hours_q         <= '0;
			minutes_q       <= '0;
			seconds_q       <= '0;
			alarm_hours_q   <= '0;
			alarm_minutes_q <= '0;
			snooze_count_q  <= '0;
			mode_q          <= acws_pkg::MODE_TIME;
			enabled_q       <= 1'b0;
			sounding_q      <= 1'b0;
			snoozing_q      <= 1'b0;
			colon_q         <= 1'b0;
			radio_q         <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (pop_fire) begin
				tick_count_q    <= tick_n;
				hours_q         <= hours_n;
				minutes_q       <= minutes_n;
				seconds_q       <= seconds_n;
				alarm_hours_q   <= alarm_hours_n;
				alarm_minutes_q <= alarm_minutes_n;
				snooze_count_q  <= snooze_count_n;
				mode_q          <= mode_n;
				enabled_q       <= enabled_n;
				sounding_q      <= sounding_n;
				snoozing_q      <= snoozing_n;
				colon_q         <= colon_n;
				radio_q         <= radio_n;
				out_valid_q     <= 1'b1;
			end else if (results.ready) begin
				out_valid_q     <= 1'b0;
			end
		end
	end

	assign results.valid          = out_valid_q;
	assign results.hours          = hours_q;
	assign results.minutes        = minutes_q;
	assign results.seconds        = seconds_q;
	assign results.alarm_hours    = alarm_hours_q;
	assign results.alarm_minutes  = alarm_minutes_q;
	assign results.display_mode   = mode_q;
	assign results.alarm_enabled  = enabled_q;
	assign results.alarm_sounding = sounding_q;
	assign results.snoozing       = snoozing_q;
	assign results.colon_on       = colon_q;
	assign results.radio_on       = radio_q;

	a_button_keeps_seconds: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire && !cmd.tick |=> $stable(seconds_q) && $stable(tick_count_q))
		else $error("button command changed the seconds or prescaler");

	a_result_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire |=> out_valid_q)
		else $error("executed command produced no result");

endmodule

// ===== src/alarm_clock_with_snooze.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_with_snooze
// Alarm clock controller with snooze: debounce front, command queue, clock back.
// ----------------------------------------------------------------------------
// An accepted item is queued; its result is registered when the back pops it.
// One item and one command per cycle while the queue has room and results drain.
// The two-entry queue lets the front accept while a result waits to be taken.
// Reset: all state clears at once, ticks_per_second to 128, snooze_seconds to 10.
// ----------------------------------------------------------------------------
module alarm_clock_with_snooze #(
	parameter int NUM_BUTTONS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	acws_in_if.sink                             items,
	acws_out_if.source                          results,
	input  logic                                wr_en,
	input  logic [acws_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [acws_pkg::CFG_DATA_W-1:0]     wr_data
);

	logic           push_valid;
	logic           push_ready;
	acws_pkg::cmd_t push_cmd;
	logic           pop_valid;
	logic           pop_ready;
	acws_pkg::cmd_t pop_cmd;

	acws_front #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_cmd   (push_cmd)
	);

	acws_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	acws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.cmd       (pop_cmd),
		.results   (results),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

endmodule
